>>> rtl/grmv_pkg.sv
package grmv_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int MEAN_W     = SAMPLE_W + FRAC_W;
    localparam int DMAG_W     = MEAN_W + 1;
    localparam int CNT_W      = 16;
    localparam int SQ_W       = 64;
    localparam int VDIV_W     = SQ_W + FRAC_W;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEP_W     = REM_W + 2;
    localparam int PROD_W     = 2 * DMAG_W;
    localparam int MUL_SPLIT  = 16;
    localparam int STEP_CNT_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STATUS_W   = 3;

    localparam logic [CNT_W-1:0] ARM_COUNT = CNT_W'(10);

    localparam logic [31:0]      RST_THRESHOLD = 32'd1179648;
    localparam logic [CNT_W-1:0] RST_TARGET    = CNT_W'(4000);
    localparam logic             RST_GATE_EN   = 1'b1;

    // floor(v/5) for 16-bit v: v * ceil(2^18/5) >> 18
    localparam int          DIV5_SHIFT = 18;
    localparam logic [16:0] DIV5_RECIP = 17'd52429;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_EN   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GATED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READ_ERR = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABORTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

    typedef struct packed {
        logic lo_en;
        logic hi_en;
    } mul_ctl_t;

    function automatic logic [CNT_W-1:0] div_by5(input logic [CNT_W-1:0] v);
        logic [CNT_W+16:0] p;
        p = v * DIV5_RECIP;
        return CNT_W'(p[CNT_W+16:DIV5_SHIFT]);
    endfunction

endpackage

>>> rtl/grmv_step.sv
// Shared compare-subtract step for restoring division and square root.
module grmv_step (
    input  logic [grmv_pkg::STEP_W-1:0] step_a,
    input  logic [grmv_pkg::STEP_W-1:0] step_b,
    output logic [grmv_pkg::STEP_W-1:0] step_diff,
    output logic                        step_ge
);

    assign step_diff = step_a - step_b;
    assign step_ge   = (step_a >= step_b);

endmodule

>>> rtl/grmv_mul.sv
// Product built in halves: low half of b first, then high half added in.
module grmv_mul (
    input  logic                        aclk,
    input  grmv_pkg::mul_ctl_t          ctl,
    input  logic [grmv_pkg::DMAG_W-1:0] mul_a,
    input  logic [grmv_pkg::DMAG_W-1:0] mul_b,
    output logic [grmv_pkg::PROD_W-1:0] prod
);

    logic [grmv_pkg::DMAG_W+grmv_pkg::MUL_SPLIT-1:0] lo_reg;
    logic [grmv_pkg::PROD_W-1:0]                     prod_reg;
    logic [grmv_pkg::PROD_W-1:0]                     hi_part;

    assign hi_part = grmv_pkg::PROD_W'(mul_a * mul_b[grmv_pkg::DMAG_W-1:grmv_pkg::MUL_SPLIT])
                     << grmv_pkg::MUL_SPLIT;

    always_ff @(posedge aclk) begin
        if (ctl.lo_en) begin
            lo_reg <= mul_a * mul_b[grmv_pkg::MUL_SPLIT-1:0];
        end
        if (ctl.hi_en) begin
            prod_reg <= grmv_pkg::PROD_W'(lo_reg) + hi_part;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/gated_running_mean_variance_core.sv
// A sample not accepted into the statistics goes S_IDLE, S_DECIDE, S_OUT; an
// accepted one runs mean division, multiply and, if due, variance division and root
// (33-step mean division, 80-step variance division, 32-step root, all on one
// shared compare-subtract unit). One item at a time; s_ready is high only when idle.
// Reset (aresetn low, synchronous) clears statistics, counters and flags and
// loads the register defaults: threshold 1179648, target 4000, gate enabled.
module gated_running_mean_variance_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [grmv_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_read_failed,
    input  logic                                s_restart,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [grmv_pkg::STATUS_W-1:0]       m_status,
    output logic [grmv_pkg::CNT_W-1:0]          m_accepted_count,
    output logic signed [grmv_pkg::MEAN_W-1:0]  m_running_mean,
    output logic [grmv_pkg::ROOT_W-1:0]         m_std_dev,
    output logic                                m_done_res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [grmv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grmv_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_DECIDE    = 11'b000_0000_0010,
        S_DIV_MEAN  = 11'b000_0000_0100,
        S_MEAN_UPD  = 11'b000_0000_1000,
        S_MUL_LO    = 11'b000_0001_0000,
        S_MUL_HI    = 11'b000_0010_0000,
        S_SQ_UPD    = 11'b000_0100_0000,
        S_DIV_VAR   = 11'b000_1000_0000,
        S_ROOT_LOAD = 11'b001_0000_0000,
        S_ROOT      = 11'b010_0000_0000,
        S_OUT       = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    logic [31:0]                    thr_reg, thr_next;
    logic [grmv_pkg::CNT_W-1:0]     target_reg, target_next;
    logic                           gate_en_reg, gate_en_next;

    logic [grmv_pkg::MEAN_W-1:0]    mean_reg, mean_next;
    logic [grmv_pkg::SQ_W-1:0]      sq_reg, sq_next;
    logic [grmv_pkg::CNT_W-1:0]     acc_reg, acc_next;
    logic [grmv_pkg::CNT_W-1:0]     err_reg, err_next;
    logic                           armed_reg, armed_next;
    logic                           fin_reg, fin_next;
    logic [grmv_pkg::ROOT_W-1:0]    std_reg, std_next;

    logic [grmv_pkg::SAMPLE_W-1:0]  x_reg, x_next;
    logic                           fail_reg, fail_next;
    logic                           restart_reg, restart_next;
    logic [grmv_pkg::VDIV_W-1:0]    work_reg, work_next;
    logic [grmv_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [grmv_pkg::ROOT_W-1:0]    root_reg, root_next;
    logic [grmv_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [grmv_pkg::DMAG_W-1:0]    dmag_reg, dmag_next;
    logic                           dsign_reg, dsign_next;
    logic [grmv_pkg::DMAG_W-1:0]    m2_reg, m2_next;
    logic [grmv_pkg::STATUS_W-1:0]  status_reg, status_next;

    logic [grmv_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [grmv_pkg::CNT_W-1:0]     m_acc_reg, m_acc_next;
    logic [grmv_pkg::MEAN_W-1:0]    m_mean_reg, m_mean_next;
    logic [grmv_pkg::ROOT_W-1:0]    m_std_reg, m_std_next;
    logic                           m_done_reg, m_done_next;

    // effective state after an optional restart
    logic [grmv_pkg::MEAN_W-1:0]    mean_eff;
    logic [grmv_pkg::SQ_W-1:0]      sq_eff;
    logic [grmv_pkg::CNT_W-1:0]     acc_eff, acc_inc, err_eff, err_inc;
    logic                           armed_eff, fin_eff;
    logic [grmv_pkg::ROOT_W-1:0]    std_eff;

    logic [grmv_pkg::DMAG_W-1:0]    delta, dmag;
    logic                           gated;
    logic [grmv_pkg::DMAG_W-1:0]    quot, mean_upd;
    logic [grmv_pkg::SQ_W:0]        sq_sum;
    logic [grmv_pkg::SQ_W-1:0]      sq_sat;

    logic [grmv_pkg::STEP_W-1:0]    step_a, step_b, step_diff;
    logic                           step_ge;
    grmv_pkg::mul_ctl_t             mul_ctl;
    logic [grmv_pkg::PROD_W-1:0]    prod;

    grmv_step u_step (
        .step_a    (step_a),
        .step_b    (step_b),
        .step_diff (step_diff),
        .step_ge   (step_ge)
    );

    grmv_mul u_mul (
        .aclk  (aclk),
        .ctl   (mul_ctl),
        .mul_a (dmag_reg),
        .mul_b (m2_reg),
        .prod  (prod)
    );

    always_comb begin
        if (state_reg == S_ROOT) begin
            step_a = {rem_reg, work_reg[grmv_pkg::VDIV_W-1 -: 2]};
            step_b = {2'b00, root_reg, 2'b01};
        end else begin
            step_a = {{(grmv_pkg::STEP_W-grmv_pkg::CNT_W-1){1'b0}},
                      rem_reg[grmv_pkg::CNT_W-1:0], work_reg[grmv_pkg::VDIV_W-1]};
            step_b = {{(grmv_pkg::STEP_W-grmv_pkg::CNT_W){1'b0}}, acc_reg};
        end
    end

    always_comb begin
        mean_eff  = restart_reg ? '0 : mean_reg;
        sq_eff    = restart_reg ? '0 : sq_reg;
        acc_eff   = restart_reg ? '0 : acc_reg;
        err_eff   = restart_reg ? '0 : err_reg;
        armed_eff = restart_reg ? 1'b0 : armed_reg;
        fin_eff   = restart_reg ? 1'b0 : fin_reg;
        std_eff   = restart_reg ? '0 : std_reg;
        acc_inc   = (acc_eff == '1) ? acc_eff : acc_eff + 1'b1;
        err_inc   = (err_eff == '1) ? err_eff : err_eff + 1'b1;

        delta = {x_reg[grmv_pkg::SAMPLE_W-1], x_reg, {grmv_pkg::FRAC_W{1'b0}}}
                - {mean_eff[grmv_pkg::MEAN_W-1], mean_eff};
        dmag  = delta[grmv_pkg::DMAG_W-1] ? -delta : delta;
        gated = armed_eff && gate_en_reg && (dmag > {1'b0, thr_reg});

        quot     = work_reg[grmv_pkg::DMAG_W-1:0];
        mean_upd = dsign_reg ? {mean_reg[grmv_pkg::MEAN_W-1], mean_reg} - quot
                             : {mean_reg[grmv_pkg::MEAN_W-1], mean_reg} + quot;

        sq_sum = {1'b0, sq_reg}
                 + (grmv_pkg::SQ_W+1)'(prod[grmv_pkg::PROD_W-1:grmv_pkg::FRAC_W]);
        sq_sat = sq_sum[grmv_pkg::SQ_W] ? '1 : sq_sum[grmv_pkg::SQ_W-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        thr_next     = thr_reg;
        target_next  = target_reg;
        gate_en_next = gate_en_reg;
        mean_next    = mean_reg;
        sq_next      = sq_reg;
        acc_next     = acc_reg;
        err_next     = err_reg;
        armed_next   = armed_reg;
        fin_next     = fin_reg;
        std_next     = std_reg;
        x_next       = x_reg;
        fail_next    = fail_reg;
        restart_next = restart_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        cnt_next     = cnt_reg;
        dmag_next    = dmag_reg;
        dsign_next   = dsign_reg;
        m2_next      = m2_reg;
        status_next  = status_reg;
        m_status_next = m_status_reg;
        m_acc_next    = m_acc_reg;
        m_mean_next   = m_mean_reg;
        m_std_next    = m_std_reg;
        m_done_next   = m_done_reg;
        mul_ctl       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                grmv_pkg::CFG_THRESHOLD: thr_next     = cfg_data;
                grmv_pkg::CFG_TARGET:    target_next  = cfg_data[grmv_pkg::CNT_W-1:0];
                grmv_pkg::CFG_GATE_EN:   gate_en_next = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    x_next       = s_sample;
                    fail_next    = s_read_failed;
                    restart_next = s_restart;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                mean_next  = mean_eff;
                sq_next    = sq_eff;
                acc_next   = acc_eff;
                err_next   = err_eff;
                armed_next = armed_eff;
                fin_next   = fin_eff;
                std_next   = std_eff;
                state_next = S_OUT;
                if (fin_eff) begin
                    status_next = grmv_pkg::ST_IGNORED;
                end else if (fail_reg) begin
                    err_next = err_inc;
                    if (err_inc > grmv_pkg::div_by5(target_reg)) begin
                        fin_next    = 1'b1;
                        status_next = grmv_pkg::ST_ABORTED;
                    end else begin
                        status_next = grmv_pkg::ST_READ_ERR;
                    end
                end else if (gated) begin
                    status_next = grmv_pkg::ST_GATED;
                end else begin
                    status_next = grmv_pkg::ST_ACCEPTED;
                    acc_next    = acc_inc;
                    if (acc_inc >= grmv_pkg::ARM_COUNT) armed_next = 1'b1;
                    if (acc_inc >= target_reg) fin_next = 1'b1;
                    dmag_next  = dmag;
                    dsign_next = delta[grmv_pkg::DMAG_W-1];
                    work_next  = {dmag, {(grmv_pkg::VDIV_W-grmv_pkg::DMAG_W){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = grmv_pkg::STEP_CNT_W'(grmv_pkg::DMAG_W - 1);
                    state_next = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN, S_DIV_VAR: begin
                rem_next  = grmv_pkg::REM_W'(step_ge ? step_diff[grmv_pkg::CNT_W-1:0]
                                                     : step_a[grmv_pkg::CNT_W-1:0]);
                work_next = {work_reg[grmv_pkg::VDIV_W-2:0], step_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = (state_reg == S_DIV_MEAN) ? S_MEAN_UPD : S_ROOT_LOAD;
                end
            end
            S_MEAN_UPD: begin
                mean_next  = mean_upd[grmv_pkg::MEAN_W-1:0];
                // |x - new mean| = |delta| - quotient, same sign as delta
                m2_next    = dmag_reg - quot;
                state_next = S_MUL_LO;
            end
            S_MUL_LO: begin
                mul_ctl.lo_en = 1'b1;
                state_next    = S_MUL_HI;
            end
            S_MUL_HI: begin
                mul_ctl.hi_en = 1'b1;
                state_next    = S_SQ_UPD;
            end
            S_SQ_UPD: begin
                sq_next = sq_sat;
                if (acc_reg < grmv_pkg::CNT_W'(2)) begin
                    std_next   = '0;
                    state_next = S_OUT;
                end else begin
                    work_next  = {sq_sat, {grmv_pkg::FRAC_W{1'b0}}};
                    rem_next   = '0;
                    cnt_next   = grmv_pkg::STEP_CNT_W'(grmv_pkg::VDIV_W - 1);
                    state_next = S_DIV_VAR;
                end
            end
            S_ROOT_LOAD: begin
                if (|work_reg[grmv_pkg::VDIV_W-1:grmv_pkg::SQ_W]) begin
                    std_next   = '1;
                    state_next = S_OUT;
                end else begin
                    work_next  = {work_reg[grmv_pkg::SQ_W-1:0], {grmv_pkg::FRAC_W{1'b0}}};
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = grmv_pkg::STEP_CNT_W'(grmv_pkg::ROOT_W - 1);
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                rem_next  = step_ge ? step_diff[grmv_pkg::REM_W-1:0]
                                    : step_a[grmv_pkg::REM_W-1:0];
                root_next = {root_reg[grmv_pkg::ROOT_W-2:0], step_ge};
                work_next = {work_reg[grmv_pkg::VDIV_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    std_next   = {root_reg[grmv_pkg::ROOT_W-2:0], step_ge};
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_acc_next    = acc_reg;
                    m_mean_next   = mean_reg;
                    m_std_next    = std_reg;
                    m_done_next   = fin_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            thr_reg     <= grmv_pkg::RST_THRESHOLD;
            target_reg  <= grmv_pkg::RST_TARGET;
            gate_en_reg <= grmv_pkg::RST_GATE_EN;
            mean_reg    <= '0;
            sq_reg      <= '0;
            acc_reg     <= '0;
            err_reg     <= '0;
            armed_reg   <= 1'b0;
            fin_reg     <= 1'b0;
            std_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            thr_reg     <= thr_next;
            target_reg  <= target_next;
            gate_en_reg <= gate_en_next;
            mean_reg    <= mean_next;
            sq_reg      <= sq_next;
            acc_reg     <= acc_next;
            err_reg     <= err_next;
            armed_reg   <= armed_next;
            fin_reg     <= fin_next;
            std_reg     <= std_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        fail_reg     <= fail_next;
        restart_reg  <= restart_next;
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        cnt_reg      <= cnt_next;
        dmag_reg     <= dmag_next;
        dsign_reg    <= dsign_next;
        m2_reg       <= m2_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_acc_reg    <= m_acc_next;
        m_mean_reg   <= m_mean_next;
        m_std_reg    <= m_std_next;
        m_done_reg   <= m_done_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_accepted_count = m_acc_reg;
    assign m_running_mean   = m_mean_reg;
    assign m_std_dev        = m_std_reg;
    assign m_done_res       = m_done_reg;

    a_std_zero_below_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && acc_reg < grmv_pkg::CNT_W'(2)) |-> (std_reg == '0))
        else $error("std dev nonzero with fewer than two samples");

    a_armed_count: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> (acc_reg >= grmv_pkg::ARM_COUNT))
        else $error("gate armed before enough samples");

    a_accepted_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == grmv_pkg::ST_ACCEPTED) |-> (m_accepted_count != '0))
        else $error("accepted item reports zero count");

    a_done_on_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == grmv_pkg::ST_ABORTED || m_status == grmv_pkg::ST_IGNORED))
        |-> m_done_res)
        else $error("abort or ignore without done");

endmodule
